@@ hw/rtl/pdd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdd_pkg: shared definitions for the phase difference detector
// Widths, pipeline control type and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package pdd_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int PHASE_W       = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int ACC_W       = 32;
  localparam int PROD_W      = 2 * SAMPLE_W;
  // conjugate product magnitude is at most 2^(PROD_W-1), CORDIC gain below 2
  localparam int VEC_W       = PROD_W + 2;
  localparam int ANGLE_IDX_W = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [VEC_W-1:0]    vec_t;
  typedef logic        [ACC_W-1:0]    acc_t;
  typedef logic signed [PHASE_W-1:0]  phase_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

  // atan(2^-i), one full turn equal to 2^32
  function automatic acc_t stage_angle(input logic [ANGLE_IDX_W-1:0] idx);
    acc_t a;
    unique case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      5'd31: a = 32'h00000000;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ hw/rtl/pdd_conj_mult.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdd_conj_mult: conjugate multiply and pre-rotation
// Three stages: partial products, real/imag sums, fold into the right half.
// ----------------------------------------------------------------------------
module pdd_conj_mult (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  pdd_pkg::sample_t a_real,
  input  pdd_pkg::sample_t a_imag,
  input  pdd_pkg::sample_t b_real,
  input  pdd_pkg::sample_t b_imag,
  output pdd_pkg::ctl_t    ctl_out,
  output pdd_pkg::vec_t    x_out,
  output pdd_pkg::vec_t    y_out,
  output pdd_pkg::acc_t    acc_out
);
  import pdd_pkg::*;

  localparam acc_t HALF_TURN = acc_t'(1) << (ACC_W - 1);

  // stage 1: products
  logic  v1_r;
  prod_t p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  // stage 2: conjugate product
  logic  v2_r;
  vec_t  x2_r, y2_r;
  vec_t  x2_nxt, y2_nxt;
  // stage 3: pre-rotated vector
  ctl_t  ctl3_r;
  vec_t  x3_r, y3_r;
  acc_t  acc3_r;

  assign x2_nxt = VEC_W'(p_rr_r) + VEC_W'(p_ii_r);
  assign y2_nxt = VEC_W'(p_ri_r) - VEC_W'(p_ir_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      ctl3_r <= '0;
    end else if (en) begin
      v1_r         <= in_valid;
      v2_r         <= v1_r;
      ctl3_r.valid <= v2_r;
      ctl3_r.zero  <= (x2_r == '0) && (y2_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_rr_r <= PROD_W'(a_real) * PROD_W'(b_real);
      p_ii_r <= PROD_W'(a_imag) * PROD_W'(b_imag);
      p_ri_r <= PROD_W'(a_real) * PROD_W'(b_imag);
      p_ir_r <= PROD_W'(b_real) * PROD_W'(a_imag);
      x2_r   <= x2_nxt;
      y2_r   <= y2_nxt;
      // fold the left half plane over by a half turn
      if (x2_r[VEC_W-1]) begin
        x3_r   <= -x2_r;
        y3_r   <= -y2_r;
        acc3_r <= HALF_TURN;
      end else begin
        x3_r   <= x2_r;
        y3_r   <= y2_r;
        acc3_r <= '0;
      end
    end
  end

  assign ctl_out = ctl3_r;
  assign x_out   = x3_r;
  assign y_out   = y3_r;
  assign acc_out = acc3_r;

endmodule

@@ hw/rtl/pdd_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdd_cordic: vectoring CORDIC, one micro-rotation per register stage
// Drives y toward zero and accumulates the rotated angle.
// ----------------------------------------------------------------------------
module pdd_cordic (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  pdd_pkg::ctl_t ctl_in,
  input  pdd_pkg::vec_t x_in,
  input  pdd_pkg::vec_t y_in,
  input  pdd_pkg::acc_t acc_in,
  output pdd_pkg::ctl_t ctl_out,
  output pdd_pkg::acc_t acc_out
);
  import pdd_pkg::*;

  ctl_t ctl_r [CORDIC_STAGES];
  vec_t x_r   [CORDIC_STAGES];
  vec_t y_r   [CORDIC_STAGES];
  acc_t acc_r [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    ctl_t ctl_src;
    vec_t x_src, y_src, x_nxt, y_nxt;
    acc_t acc_src, acc_nxt, ang;

    if (i == 0) begin : g_first
      assign ctl_src = ctl_in;
      assign x_src   = x_in;
      assign y_src   = y_in;
      assign acc_src = acc_in;
    end else begin : g_next
      assign ctl_src = ctl_r[i-1];
      assign x_src   = x_r[i-1];
      assign y_src   = y_r[i-1];
      assign acc_src = acc_r[i-1];
    end

    assign ang = stage_angle(ANGLE_IDX_W'(i));

    always_comb begin
      if (!y_src[VEC_W-1]) begin
        x_nxt   = x_src + (y_src >>> i);
        y_nxt   = y_src - (x_src >>> i);
        acc_nxt = acc_src + ang;
      end else begin
        x_nxt   = x_src - (y_src >>> i);
        y_nxt   = y_src + (x_src >>> i);
        acc_nxt = acc_src - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else if (en) begin
        ctl_r[i] <= ctl_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]   <= x_nxt;
        y_r[i]   <= y_nxt;
        acc_r[i] <= acc_nxt;
      end
    end
  end

  assign ctl_out = ctl_r[CORDIC_STAGES-1];
  assign acc_out = acc_r[CORDIC_STAGES-1];

endmodule

@@ hw/rtl/pdd_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdd_round: angle rounding and output register
// Rounds the turn accumulator to the phase width and holds it for the sink.
// ----------------------------------------------------------------------------
module pdd_round (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  pdd_pkg::ctl_t  ctl_in,
  input  pdd_pkg::acc_t  acc_in,
  output logic           out_valid,
  output pdd_pkg::phase_t out_phase_diff
);
  import pdd_pkg::*;

  localparam acc_t RND_HALF = acc_t'(1) << (ACC_W - 1 - PHASE_W);

  logic   valid_r;
  phase_t phase_r;
  acc_t   rounded;
  phase_t phase_nxt;

  assign rounded   = acc_in + RND_HALF;
  // zero vector has no angle: report zero
  assign phase_nxt = ctl_in.zero ? '0 : phase_t'(rounded[ACC_W-1 -: PHASE_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase_r <= phase_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_phase_diff = phase_r;

endmodule

@@ hw/rtl/phase_difference_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_difference_detector: phase of sample B relative to sample A
// Conjugate multiply followed by a pipelined vectoring CORDIC atan2.
// ----------------------------------------------------------------------------
// One transaction enters every clock unless the pipeline is stalled. It passes
// through the conjugate multiply and pre-rotation stages, one register stage per
// CORDIC micro-rotation, and the rounding stage into the output register. The
// fully pipelined CORDIC sets the rate of one transaction per clock. When the
// output holds a result and out_stall is high, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is dropped or repeated. The phase
// is a signed binary angle, 32768 units per pi; +pi wraps to -32768 and a
// zero vector gives 0.
// ----------------------------------------------------------------------------
module phase_difference_detector (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pdd_pkg::sample_t in_a_real,
  input  pdd_pkg::sample_t in_a_imag,
  input  pdd_pkg::sample_t in_b_real,
  input  pdd_pkg::sample_t in_b_imag,
  output logic            out_valid,
  input  logic            out_stall,
  output pdd_pkg::phase_t out_phase_diff
);
  import pdd_pkg::*;

  logic en;
  ctl_t cm_ctl, cd_ctl;
  vec_t cm_x, cm_y;
  acc_t cm_acc, cd_acc;

  // advance unless a held result is stalled
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  pdd_conj_mult u_conj_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .a_real   (in_a_real),
    .a_imag   (in_a_imag),
    .b_real   (in_b_real),
    .b_imag   (in_b_imag),
    .ctl_out  (cm_ctl),
    .x_out    (cm_x),
    .y_out    (cm_y),
    .acc_out  (cm_acc)
  );

  pdd_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (cm_ctl),
    .x_in    (cm_x),
    .y_in    (cm_y),
    .acc_in  (cm_acc),
    .ctl_out (cd_ctl),
    .acc_out (cd_acc)
  );

  pdd_round u_round (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .ctl_in         (cd_ctl),
    .acc_in         (cd_acc),
    .out_valid      (out_valid),
    .out_phase_diff (out_phase_diff)
  );

endmodule

@@ hw/rtl/pdd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdd_checker: port-level checks for the phase difference detector
// Watches the handshakes on the top level and flags protocol slips.
// ----------------------------------------------------------------------------
module pdd_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input pdd_pkg::phase_t out_phase_diff
);
  import pdd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_phase_diff))
    else $error("stalled result changed");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // free-running output never blocks the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // after reset no result can show up before a transaction crosses every stage
  a_min_latency: assert property (@(posedge clk)
    !rst_n |=> !out_valid [*19])
    else $error("result appeared sooner than the pipeline depth");

endmodule

bind phase_difference_detector pdd_checker u_pdd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_phase_diff (out_phase_diff)
);
